// File: design/seven_segment_rect_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Seven-segment rect generator assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_RECT_GENERATOR_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_RECT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SRG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srg assertion failed (same cycle)");

// next-cycle implication
`define SRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srg assertion failed (next cycle)");

`endif

// File: design/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Types, constants and helpers shared by the seven-segment rect generator.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

  localparam int COORD_W  = 16;
  localparam int PC_W     = 12;
  localparam int COL_W    = 8;
  localparam int VAL_W    = 8;
  localparam int FH_W     = 8;
  localparam int T_W      = 5;   // thickness, boosted, max 25
  localparam int LEN_W    = 7;   // segment length, max 102
  localparam int OFF_W    = 9;   // offset inside one glyph
  localparam int PAT_W    = 7;
  localparam int NUM_SEGS = 7;
  localparam int NUM_RECTS = 2 * NUM_SEGS;
  localparam int IDX_W    = 4;
  localparam int SEG_W    = 3;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 88;

  // x/10 == (x*205) >> 11 for every 8-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd205;
  localparam int          DIV10_SHIFT = 11;

  localparam logic [FH_W-1:0]  BOOST_LIMIT = 8'd40;
  localparam logic [T_W-1:0]   BOOST_T     = 5'd2;
  localparam logic [VAL_W-1:0] BLANK_VALUE = 8'd255;
  localparam logic [VAL_W-1:0] MAX_DIGIT   = 8'd9;

  typedef enum logic [0:0] {
    CMD_DIGIT  = 1'b0,
    CMD_NUMBER = 1'b1
  } cmd_t;

  typedef enum logic [SEG_W-1:0] {
    SEG_A, SEG_B, SEG_C, SEG_D, SEG_E, SEG_F, SEG_G
  } seg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VAL_W-1:0]   value;
    logic [FH_W-1:0]    fh;
    logic [COL_W-1:0]   ink;
  } req_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VAL_W-1:0]   value;
    logic [FH_W-1:0]    fh;
    logic [COL_W-1:0]   ink;
    logic [T_W-1:0]     t0;
    logic [T_W-1:0]     tens;
  } s1_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y;
    logic [T_W-1:0]     t;
    logic [LEN_W-1:0]   len;
    logic [PAT_W-1:0]   pat0;
    logic [PAT_W-1:0]   pat1;
    logic               en0;
    logic               en1;
    logic [COL_W-1:0]   ink;
  } s2_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y;
    logic [T_W-1:0]     t;
    logic [LEN_W-1:0]   len;
    logic [OFF_W-1:0]   o_lt;    // len + t
    logic [OFF_W-1:0]   o_2tl;   // 2t + len
    logic [OFF_W-1:0]   o_2t2l;  // 2t + 2len
    logic [PC_W-1:0]    pc;
    logic [PAT_W-1:0]   pat0;
    logic [PAT_W-1:0]   pat1;
    logic               en0;
    logic               en1;
    logic [COL_W-1:0]   ink;
  } geom_t;

  typedef struct packed {
    logic [NUM_RECTS-1:0][COORD_W-1:0] cx;
    logic [NUM_RECTS-1:0][COORD_W-1:0] cy;
    logic [NUM_RECTS-1:0]              keep;
    logic [NUM_RECTS-1:0]              lit;
    logic [T_W-1:0]                    t;
    logic [LEN_W-1:0]                  len;
    logic [PC_W-1:0]                   pc;
    logic [COL_W-1:0]                  ink;
  } place_t;

  typedef struct packed {
    logic [COL_W-1:0]   colour;
    logic [PC_W-1:0]    pc;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xs;
  } rect_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic last_pick;
  } emit_stat_t;

  // segment pattern, A in bit 6 down to G in bit 0
  function automatic logic [PAT_W-1:0] glyph(input logic [3:0] d);
    logic [PAT_W-1:0] p;
    case (d)
      4'd0: p = 7'b1111110;
      4'd1: p = 7'b0110000;
      4'd2: p = 7'b1101101;
      4'd3: p = 7'b1111001;
      4'd4: p = 7'b0110011;
      4'd5: p = 7'b1011011;
      4'd6: p = 7'b1011111;
      4'd7: p = 7'b1110000;
      4'd8: p = 7'b1111111;
      4'd9: p = 7'b1110011;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic seg_horiz(input seg_t s);
    return (s == SEG_A) || (s == SEG_D) || (s == SEG_G);
  endfunction

  function automatic logic [OFF_W-1:0] seg_dx(input seg_t s, input geom_t g);
    logic [OFF_W-1:0] d;
    case (s)
      SEG_A, SEG_D, SEG_G: d = OFF_W'(g.t);
      SEG_B, SEG_C:        d = g.o_lt;
      default:             d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [OFF_W-1:0] seg_dy(input seg_t s, input geom_t g);
    logic [OFF_W-1:0] d;
    case (s)
      SEG_B, SEG_F: d = OFF_W'(g.t);
      SEG_C, SEG_E: d = g.o_2tl;
      SEG_D:        d = g.o_2t2l;
      SEG_G:        d = g.o_lt;
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: design/srg_geom.sv
// ----------------------------------------------------------------------------
// srg_geom
// Three-stage front end: divide by ten, glyph decode, segment offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_geom import srg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  geom_valid,
  input  logic  geom_ready,
  output geom_t geom
);

  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  geom_t s3_r, s3_nxt;
  logic  s1_v_r, s2_v_r, s3_v_r;
  logic  rdy1, rdy2, rdy3;

  assign rdy3 = !s3_v_r || geom_ready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign req_ready  = rdy1;
  assign geom_valid = s3_v_r;
  assign geom       = s3_r;

  // stage 1: thickness and tens digit by reciprocal multiply
  always_comb begin
    logic [15:0] fh_prod;
    logic [15:0] v_prod;
    fh_prod = {8'd0, req.fh} * DIV10_MUL;
    v_prod  = {8'd0, req.value} * DIV10_MUL;
    s1_nxt.cmd   = req.cmd;
    s1_nxt.x     = req.x;
    s1_nxt.y     = req.y;
    s1_nxt.value = req.value;
    s1_nxt.fh    = req.fh;
    s1_nxt.ink   = req.ink;
    s1_nxt.t0    = T_W'(fh_prod >> DIV10_SHIFT);
    s1_nxt.tens  = T_W'(v_prod >> DIV10_SHIFT);
  end

  // stage 2: ones digit, length, boosted thickness, patterns
  always_comb begin
    logic [VAL_W-1:0] tens_x10;
    logic [3:0]       ones;
    logic [FH_W-1:0]  len_x2;
    logic [9:0]       fh_x3;
    tens_x10 = {s1_r.tens, 3'b000} + {2'b00, s1_r.tens, 1'b0};
    ones     = 4'(s1_r.value - tens_x10);
    len_x2   = s1_r.fh - {2'b00, s1_r.t0, 1'b0};
    fh_x3    = {1'b0, s1_r.fh, 1'b0} + {2'b00, s1_r.fh};
    s2_nxt.x   = s1_r.x;
    s2_nxt.y   = s1_r.y;
    s2_nxt.x2  = s1_r.x + COORD_W'(fh_x3[9:1]);
    s2_nxt.t   = (s1_r.fh < BOOST_LIMIT) ? s1_r.t0 + BOOST_T : s1_r.t0;
    s2_nxt.len = len_x2[LEN_W:1];
    s2_nxt.ink = s1_r.ink;
    if (s1_r.cmd == CMD_DIGIT) begin
      s2_nxt.pat0 = (s1_r.value <= MAX_DIGIT) ? glyph(s1_r.value[3:0]) : '0;
      s2_nxt.en0  = (s1_r.value <= MAX_DIGIT) || (s1_r.value == BLANK_VALUE);
      s2_nxt.pat1 = '0;
      s2_nxt.en1  = 1'b0;
    end else begin
      s2_nxt.pat0 = glyph(ones);
      s2_nxt.en0  = 1'b1;
      s2_nxt.pat1 = glyph(s1_r.tens[3:0]);
      s2_nxt.en1  = (VAL_W'(s1_r.tens) <= MAX_DIGIT);
    end
  end

  // stage 3: offset sums and the shared pixel count
  always_comb begin
    s3_nxt.x      = s2_r.x;
    s3_nxt.x2     = s2_r.x2;
    s3_nxt.y      = s2_r.y;
    s3_nxt.t      = s2_r.t;
    s3_nxt.len    = s2_r.len;
    s3_nxt.o_lt   = OFF_W'(s2_r.len) + OFF_W'(s2_r.t);
    s3_nxt.o_2tl  = OFF_W'(s2_r.len) + {3'b000, s2_r.t, 1'b0};
    s3_nxt.o_2t2l = {1'b0, s2_r.len, 1'b0} + {3'b000, s2_r.t, 1'b0};
    s3_nxt.pc     = PC_W'(s2_r.len * s2_r.t);
    s3_nxt.pat0   = s2_r.pat0;
    s3_nxt.pat1   = s2_r.pat1;
    s3_nxt.en0    = s2_r.en0;
    s3_nxt.en1    = s2_r.en1;
    s3_nxt.ink    = s2_r.ink;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= req_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && req_valid) s1_r <= s1_nxt;
    if (rdy2 && s1_v_r)    s2_r <= s2_nxt;
    if (rdy3 && s2_v_r)    s3_r <= s3_nxt;
  end

endmodule

`default_nettype wire

// File: design/srg_place.sv
// ----------------------------------------------------------------------------
// srg_place
// Places all fourteen rectangles and marks the enabled ones that fit the display.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_place import srg_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   geom_valid,
  output logic   geom_ready,
  input  geom_t  geom,
  output logic   place_valid,
  input  logic   place_ready,
  output place_t place
);

  place_t place_r, place_nxt;
  logic   v_r;
  logic   rdy;

  assign rdy         = !v_r || place_ready;
  assign geom_ready  = rdy;
  assign place_valid = v_r;
  assign place       = place_r;

  // one lane per rectangle, glyph-major, A..G within a glyph
  always_comb begin
    seg_t               s;
    logic [COORD_W-1:0] bx;
    logic [LEN_W-1:0]   w;
    logic [LEN_W-1:0]   h;
    logic [COORD_W:0]   xsum;
    logic [COORD_W:0]   ysum;
    logic               en;
    logic [PAT_W-1:0]   pat;
    place_nxt.t   = geom.t;
    place_nxt.len = geom.len;
    place_nxt.pc  = geom.pc;
    place_nxt.ink = geom.ink;
    for (int i = 0; i < NUM_RECTS; i++) begin
      s   = seg_t'(SEG_W'((i < NUM_SEGS) ? i : i - NUM_SEGS));
      bx  = (i < NUM_SEGS) ? geom.x : geom.x2;
      en  = (i < NUM_SEGS) ? geom.en0 : geom.en1;
      pat = (i < NUM_SEGS) ? geom.pat0 : geom.pat1;
      w   = seg_horiz(s) ? geom.len : LEN_W'(geom.t);
      h   = seg_horiz(s) ? LEN_W'(geom.t) : geom.len;
      place_nxt.cx[i] = bx + COORD_W'(seg_dx(s, geom));
      place_nxt.cy[i] = geom.y + COORD_W'(seg_dy(s, geom));
      xsum = {1'b0, place_nxt.cx[i]} + (COORD_W+1)'(w);
      ysum = {1'b0, place_nxt.cy[i]} + (COORD_W+1)'(h);
      place_nxt.keep[i] = en && (xsum <= (COORD_W+1)'(DISPLAY_WIDTH))
                             && (ysum <= (COORD_W+1)'(DISPLAY_HEIGHT));
      place_nxt.lit[i]  = pat[PAT_W-1-int'(s)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= geom_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && geom_valid) place_r <= place_nxt;
  end

endmodule

`default_nettype wire

// File: design/srg_emit.sv
// ----------------------------------------------------------------------------
// srg_emit
// Serializes the kept rectangles of one request into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_emit import srg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             place_valid,
  output logic             place_ready,
  input  place_t           place,
  input  logic [COL_W-1:0] bg_colour,
  output logic             out_valid,
  input  logic             out_ready,
  output rect_t            out_rect,
  output logic             out_last,
  output emit_stat_t       stat
);

  logic [NUM_RECTS-1:0][COORD_W-1:0] cx_r, cy_r;
  logic [NUM_RECTS-1:0] mask_r, mask_nxt;
  logic [NUM_RECTS-1:0] lit_r;
  logic [T_W-1:0]       t_r;
  logic [LEN_W-1:0]     len_r;
  logic [PC_W-1:0]      pc_r;
  logic [COL_W-1:0]     ink_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r;
  rect_t                rect_r, rect_nxt;

  logic                 busy, emit, load, last_pick, found;
  logic [IDX_W-1:0]     idx;
  logic [NUM_RECTS-1:0] pick;
  seg_t                 seg;
  logic [LEN_W-1:0]     w, h;

  // lowest pending rectangle goes first
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < NUM_RECTS; i++) begin
      if (mask_r[i] && !found) begin
        idx   = IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign pick      = NUM_RECTS'(1) << idx;
  assign busy      = |mask_r;
  assign last_pick = ((mask_r & ~pick) == '0);
  assign emit      = busy && (!out_valid_r || out_ready);
  assign load      = !busy || (emit && last_pick);
  assign place_ready = load;

  assign seg = seg_t'(SEG_W'((idx < IDX_W'(NUM_SEGS)) ? idx : idx - IDX_W'(NUM_SEGS)));
  assign w   = seg_horiz(seg) ? len_r : LEN_W'(t_r);
  assign h   = seg_horiz(seg) ? LEN_W'(t_r) : len_r;

  always_comb begin
    rect_nxt.xs     = cx_r[idx];
    rect_nxt.ys     = cy_r[idx];
    rect_nxt.xe     = cx_r[idx] + COORD_W'(w) - COORD_W'(1);
    rect_nxt.ye     = cy_r[idx] + COORD_W'(h) - COORD_W'(1);
    rect_nxt.pc     = pc_r;
    rect_nxt.colour = lit_r[idx] ? ink_r : bg_colour;
  end

  always_comb begin
    if (load) begin
      mask_nxt = place_valid ? place.keep : '0;
    end else if (emit) begin
      mask_nxt = mask_r & ~pick;
    end else begin
      mask_nxt = mask_r;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && place_valid) begin
      cx_r  <= place.cx;
      cy_r  <= place.cy;
      lit_r <= place.lit;
      t_r   <= place.t;
      len_r <= place.len;
      pc_r  <= place.pc;
      ink_r <= place.ink;
    end
    if (emit) begin
      rect_r     <= rect_nxt;
      out_last_r <= last_pick;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rect  = rect_r;
  assign out_last  = out_last_r;

  assign stat.busy      = busy;
  assign stat.emit      = emit;
  assign stat.last_pick = last_pick;

endmodule

`default_nettype wire

// File: design/seven_segment_rect_generator_core.sv
// ----------------------------------------------------------------------------
// seven_segment_rect_generator_core
// Turns seven-segment draw requests into fill-rectangle commands.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tuser: command; tdata: origin_x, origin_y, value,
//          |           |   char_height, ink_colour
//  out_    | master    | tdata: win_x/y_start, win_x/y_end, pixel_count,
//          |           |   fill_colour; tlast: last
//  cfg_    | write     | data: background_colour, always ready
//
// A request passes four register stages, then the serializer sends one
// rectangle per cycle while out_tready is high, up to 14 per request.
// The serializer and its output register set the rate. Synchronous
// active-low reset clears all valid bits and the background colour.
// Stalls hold every stage in place.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_rect_generator_core_assert.svh"

module seven_segment_rect_generator_core import srg_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // origin_x, origin_y, value, char_height, ink_colour
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // win_x_start, win_y_start, win_x_end, win_y_end, pixel_count, fill_colour
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COL_W-1:0]       cfg_data
);

  logic [COL_W-1:0] bg_r, bg_nxt;
  req_t       req;
  geom_t      geom;
  place_t     place;
  rect_t      rect;
  emit_stat_t stat;
  logic       geom_valid, geom_ready;
  logic       place_valid, place_ready;

  assign cfg_ready = 1'b1;
  assign bg_nxt    = (cfg_valid && cfg_ready) ? cfg_data : bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= '0;
    end else begin
      bg_r <= bg_nxt;
    end
  end

  assign req.cmd   = cmd_t'(in_tuser);
  assign req.x     = in_tdata[15:0];
  assign req.y     = in_tdata[31:16];
  assign req.value = in_tdata[39:32];
  assign req.fh    = in_tdata[47:40];
  assign req.ink   = in_tdata[55:48];

  srg_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready),
    .geom       (geom)
  );

  srg_place #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_place (
    .clk         (clk),
    .rst_n       (rst_n),
    .geom_valid  (geom_valid),
    .geom_ready  (geom_ready),
    .geom        (geom),
    .place_valid (place_valid),
    .place_ready (place_ready),
    .place       (place)
  );

  srg_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .place_valid (place_valid),
    .place_ready (place_ready),
    .place       (place),
    .bg_colour   (bg_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rect    (rect),
    .out_last    (out_tlast),
    .stat        (stat)
  );

  assign out_tdata = {4'b0000, rect.colour, rect.pc, rect.ye, rect.xe, rect.ys, rect.xs};

  `SRG_ASSERT_NEXT(a_emit_fills_out, stat.emit, out_tvalid)
  `SRG_ASSERT_NEXT(a_last_marked, stat.emit && stat.last_pick, out_tlast)
  `SRG_ASSERT_NEXT(a_mid_unmarked, stat.emit && !stat.last_pick, !out_tlast)
  `SRG_ASSERT_SAME(a_no_overwrite, out_tvalid && !out_tready, !stat.emit)

endmodule

`default_nettype wire

// File: verif/rect_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_stream_checker
// Watches the request, rectangle and background channels of the seven-segment
// rect generator, predicts the rectangles each request must produce and
// compares every rectangle transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module rect_stream_checker import srg_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // origin_x, origin_y, value, char_height, ink_colour
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // win_x_start, win_y_start, win_x_end, win_y_end, pixel_count, fill_colour
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [COL_W-1:0]       cfg_data,
  output int                     mismatch_count,
  output int                     rects_pending
);

  typedef struct packed {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [PC_W-1:0]    pc;
    logic [COL_W-1:0]   colour;
    logic               last;
  } fill_rect_t;

  // lit segments per digit, A in bit 6 down to G in bit 0
  localparam logic [PAT_W-1:0] DIGIT_SEGS [10] = '{
    7'b1111110, 7'b0110000, 7'b1101101, 7'b1111001, 7'b0110011,
    7'b1011011, 7'b1011111, 7'b1110000, 7'b1111111, 7'b1110011
  };

  fill_rect_t       rects_due[$];
  fill_rect_t       glyph_batch[$];
  logic [COL_W-1:0] bg_colour;

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // corner wraps to 16 bits first; the edge test itself does not wrap
  function automatic void add_rect(input int unsigned x, input int unsigned y,
                                   input int unsigned w, input int unsigned h,
                                   input logic [COL_W-1:0] colour);
    fill_rect_t r;
    x = x & 32'hFFFF;
    y = y & 32'hFFFF;
    if (x + w > DISPLAY_WIDTH || y + h > DISPLAY_HEIGHT) return;
    r.xs     = x[15:0];
    r.ys     = y[15:0];
    r.xe     = 16'(x + w - 1);
    r.ye     = 16'(y + h - 1);
    r.pc     = 12'(w * h);
    r.colour = colour;
    r.last   = 1'b0;
    glyph_batch.push_back(r);
  endfunction

  function automatic void add_glyph(input int unsigned x, input int unsigned y,
                                    input logic [PAT_W-1:0] pat,
                                    input logic [FH_W-1:0] fh,
                                    input logic [COL_W-1:0] ink);
    int unsigned thick;
    int unsigned seg_len;
    int unsigned dx[NUM_SEGS];
    int unsigned dy[NUM_SEGS];
    int unsigned w[NUM_SEGS];
    int unsigned h[NUM_SEGS];
    thick   = fh / 10;
    // length uses the thickness before the small-font boost
    seg_len = (fh - 2 * thick) / 2;
    if (fh < BOOST_LIMIT) thick += BOOST_T;
    dx = '{thick, seg_len + thick, seg_len + thick, thick, 0, 0, thick};
    dy = '{0, thick, 2 * thick + seg_len, 2 * thick + 2 * seg_len,
           2 * thick + seg_len, thick, thick + seg_len};
    w  = '{seg_len, thick, thick, seg_len, thick, thick, seg_len};
    h  = '{thick, seg_len, seg_len, thick, seg_len, seg_len, thick};
    for (int s = 0; s < NUM_SEGS; s++) begin
      add_rect(x + dx[s], y + dy[s], w[s], h[s], pat[6 - s] ? ink : bg_colour);
    end
  endfunction

  function automatic void predict_rects(input req_t r);
    int unsigned ones;
    int unsigned tens;
    glyph_batch.delete();
    if (r.cmd == CMD_DIGIT) begin
      if (r.value <= MAX_DIGIT) begin
        add_glyph(r.x, r.y, DIGIT_SEGS[r.value], r.fh, r.ink);
      end else if (r.value == BLANK_VALUE) begin
        add_glyph(r.x, r.y, '0, r.fh, r.ink);
      end
    end else begin
      ones = r.value % 10;
      tens = r.value / 10;
      add_glyph(r.x, r.y, DIGIT_SEGS[ones], r.fh, r.ink);
      if (tens <= 9) add_glyph(r.x + (r.fh * 3) / 2, r.y, DIGIT_SEGS[tens], r.fh, r.ink);
    end
    if (glyph_batch.size() > 0) glyph_batch[glyph_batch.size() - 1].last = 1'b1;
    foreach (glyph_batch[i]) rects_due.push_back(glyph_batch[i]);
  endfunction

  always @(posedge clk) begin
    fill_rect_t want;
    req_t       req;
    if (!rst_n) begin
      bg_colour      = '0;
      mismatch_count = 0;
      rects_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) bg_colour = cfg_data;
      // retire before predicting: a request never yields a rectangle in its own cycle
      if (out_tvalid && out_tready) begin
        if (rects_due.size() == 0) begin
          $error("rectangle transfer with no rectangle expected");
          mismatch_count++;
        end else begin
          want = rects_due.pop_front();
          check_field("win_x_start", want.xs, out_tdata[15:0]);
          check_field("win_y_start", want.ys, out_tdata[31:16]);
          check_field("win_x_end", want.xe, out_tdata[47:32]);
          check_field("win_y_end", want.ye, out_tdata[63:48]);
          check_field("pixel_count", 16'(want.pc), 16'(out_tdata[75:64]));
          check_field("fill_colour", 16'(want.colour), 16'(out_tdata[83:76]));
          check_field("last", 16'(want.last), 16'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        req.cmd   = cmd_t'(in_tuser);
        req.x     = in_tdata[15:0];
        req.y     = in_tdata[31:16];
        req.value = in_tdata[39:32];
        req.fh    = in_tdata[47:40];
        req.ink   = in_tdata[55:48];
        predict_rects(req);
      end
    end
    rects_pending = rects_due.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives draw requests and background writes into the seven-segment rect
// generator, with random source and sink stalls before phase 5; the checker does the rest.
// ----------------------------------------------------------------------------
module tb;
  import srg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 7;
  localparam int RAND_PER_PHASE = 48;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [COL_W-1:0]       cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatch_count;
  int rects_pending;

  seven_segment_rect_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  rect_stream_checker rect_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .rects_pending  (rects_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {r.ink, r.fh, r.value, r.y, r.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_fields(input cmd_t c, input int x, input int y, input int value,
                             input int fh, input int ink);
    req_t r;
    r.cmd   = c;
    r.x     = 16'(x);
    r.y     = 16'(y);
    r.value = 8'(value);
    r.fh    = 8'(fh);
    r.ink   = 8'(ink);
    send_request(r);
  endtask

  // also covers requests that yield nothing but may still be in flight
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rects_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_background(input logic [COL_W-1:0] colour);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= colour;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly on-screen glyphs, some wrapped or fully random corners
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.cmd = cmd_t'($urandom_range(0, 1));
    pick  = $urandom_range(0, 99);
    if (r.cmd == CMD_DIGIT) begin
      r.value = pick < 75 ? 8'($urandom_range(0, 9)) :
                pick < 87 ? BLANK_VALUE : 8'($urandom_range(0, 255));
    end else begin
      r.value = pick < 70 ? 8'($urandom_range(0, 99)) : 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    r.fh = pick < 55 ? 8'($urandom_range(8, 80)) :
           pick < 80 ? 8'($urandom_range(0, 39)) : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    r.x  = pick < 70 ? 16'($urandom_range(0, 470)) :
           pick < 85 ? 16'($urandom_range(65400, 65535)) : 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    r.y  = pick < 75 ? 16'($urandom_range(0, 319)) : 16'($urandom_range(0, 65535));
    r.ink = 8'($urandom_range(0, 255));
    return r;
  endfunction

  initial begin
    logic [COL_W-1:0] bg_plan [PHASES];
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    cycle_count   = 0;
    send_idle_pct = 33;
    recv_idle_pct = 51;
    bg_plan = '{8'hA5, 8'h00, 8'hFF, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h01};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 33;
      end
      if (phase == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_background(bg_plan[phase]);
      if (phase == 0) begin
        for (int d = 0; d < 10; d++) send_fields(CMD_DIGIT, 10, 10, d, 30, 16 + d);
        send_fields(CMD_DIGIT, 100, 20, 255, 60, 8'h3C);    // blank glyph
        send_fields(CMD_DIGIT, 10, 10, 10, 30, 8'h11);      // no output
        send_fields(CMD_DIGIT, 10, 10, 254, 30, 8'h22);     // no output
        send_fields(CMD_NUMBER, 0, 0, 0, 20, 8'h33);        // tens drawn as zero
        send_fields(CMD_NUMBER, 0, 0, 99, 40, 8'h44);       // boost threshold
        send_fields(CMD_NUMBER, 0, 0, 100, 39, 8'h55);      // tens out of range
        send_fields(CMD_NUMBER, 0, 0, 255, 255, 8'h66);
        send_fields(CMD_DIGIT, 0, 0, 8, 0, 8'h77);          // zero-size rects
        send_fields(CMD_DIGIT, 0, 41, 8, 255, 8'h88);       // touches bottom edge
        send_fields(CMD_DIGIT, 65530, 0, 8, 100, 8'h99);    // corner wraps
        send_fields(CMD_DIGIT, 470, 300, 8, 50, 8'hAA);     // fully off-screen
        send_fields(CMD_NUMBER, 300, 0, 42, 255, 8'hBB);    // tens off-screen
        send_fields(CMD_DIGIT, 65535, 65535, 1, 255, 255);
        send_fields(CMD_NUMBER, 479, 319, 57, 9, 0);
      end else begin
        for (int n = 0; n < RAND_PER_PHASE; n++) begin
          if (phase == 1 && n == RAND_PER_PHASE / 2) wait_drained();
          send_request(random_request());
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
